/* rtl/dctt_pkg.sv */
// Shared types and constants of the deferred call timer table.
package dctt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic [1:0] {
      CMD_SCHEDULE = 2'd0,
      CMD_CANCEL   = 2'd1,
      CMD_TICK     = 2'd2,
      CMD_RSVD     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_RSVD      = 2'd3
   } status_type;

   localparam logic KIND_STATUS  = 1'b0;
   localparam logic KIND_EXPIRED = 1'b1;

   typedef enum logic [1:0] {
      UOP_ADD,
      UOP_EQ,
      UOP_PAST
   } unit_op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] callback_key;
      logic [31:0] argument;
      logic [30:0] delay_ticks;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  status;
      logic [31:0] expired_key;
      logic [31:0] expired_argument;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] argument;
      logic [31:0] deadline;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic [IDX_W-1:0] raddr;
   } tbl_ctl_type;

endpackage

/* rtl/deferred_call_timer_table.sv */
// Top level of the deferred call timer table: sequencer, state and result register.
//
// Usage:
//   req_* carries one command per transfer: schedule (append key, argument and
//   deadline now + delay_ticks), cancel (drop the oldest entry with a matching
//   key) or tick (advance the time counter, then drop and report every entry
//   whose deadline is strictly behind it, in insertion order).
//   rsp_* carries results. Schedule and cancel give one status transfer with
//   last set. A tick gives one transfer per expired entry, last on the final
//   one, or nothing when no entry expires. Command code three is dropped.
//   Timing: req_ready is high only while the sequencer is idle. Schedule goes
//   from accept through the finish state back to idle. Cancel and tick read
//   and then evaluate each stored entry in turn before finishing: the table
//   has a single read port with a registered output, and every entry passes
//   through the one shared subtract/compare unit. The result register lets
//   the next command be taken while a result still waits.
//   A stalled rsp_ready holds the sequencer at the point where it must hand
//   over another result; nothing is lost or reordered.
//   Reset empties the table and clears the time counter to zero; entry
//   contents are not cleared, only the entry count.
module deferred_call_timer_table
   import dctt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // control state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] idx_ff;      // read position of the compaction scan
   logic [CNT_W-1:0] wr_ff;       // write position of the compaction scan
   logic             found_ff;    // cancel already removed its entry
   logic             pend_valid_ff;
   logic             rsp_valid_ff;
   logic [31:0]      now_ff;

   // latched command and pending expired entry
   cmd_type          cmd_ff;
   logic [31:0]      key_ff;
   logic [31:0]      arg_ff;
   logic [30:0]      delay_ff;
   logic [31:0]      pend_key_ff;
   logic [31:0]      pend_arg_ff;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic             out_free;
   logic             last_entry;
   cmd_type          req_cmd;

   // sequencer outputs
   unit_op_type      unit_op;
   logic [31:0]      unit_a;
   logic [31:0]      unit_b;
   logic [31:0]      unit_res;
   logic             unit_hit;
   logic             remove;
   logic             stall;
   logic             load_rsp;
   tbl_ctl_type      tbl_ctl;
   entry_type        rd_entry;

   assign req_cmd    = cmd_type'(req_data.command);
   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign last_entry = ((idx_ff + CNT_W'(1)) == count_ff);

   dctt_table u_table (
      .clock   (clock),
      .ctl     (tbl_ctl),
      .rd_data (rd_entry)
   );

   dctt_unit u_unit (
      .op  (unit_op),
      .a   (unit_a),
      .b   (unit_b),
      .res (unit_res),
      .hit (unit_hit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_SCHEDULE: state_in = S_FINISH;
                  CMD_CANCEL, CMD_TICK: begin
                     state_in = (count_ff == '0) ? S_FINISH : S_READ;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_READ: state_in = S_EVAL;
         S_EVAL: begin
            if (!stall) begin
               state_in = last_entry ? S_FINISH : S_READ;
            end
         end
         S_FINISH: begin
            if (!stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready     = 1'b0;
      unit_op       = UOP_ADD;
      unit_a        = now_ff;
      unit_b        = 32'd1;
      remove        = 1'b0;
      stall         = 1'b0;
      load_rsp      = 1'b0;
      rsp_in        = '0;
      rsp_in.kind   = KIND_STATUS;
      rsp_in.last   = 1'b1;
      tbl_ctl.we    = 1'b0;
      tbl_ctl.waddr = wr_ff[IDX_W-1:0];
      tbl_ctl.wdata = rd_entry;
      tbl_ctl.raddr = idx_ff[IDX_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            // unit advances the time counter
            req_ready = 1'b1;
         end
         S_READ: begin
         end
         S_EVAL: begin
            if (cmd_ff == CMD_TICK) begin
               unit_op = UOP_PAST;
               unit_a  = now_ff;
               unit_b  = rd_entry.deadline;
               remove  = unit_hit;
            end else begin
               unit_op = UOP_EQ;
               unit_a  = key_ff;
               unit_b  = rd_entry.key;
               remove  = unit_hit && !found_ff;
            end
            // a second expiry pushes the held one out
            if (remove && (cmd_ff == CMD_TICK) && pend_valid_ff) begin
               stall    = !out_free;
               load_rsp = out_free;
               rsp_in.kind             = KIND_EXPIRED;
               rsp_in.status           = STAT_OK;
               rsp_in.expired_key      = pend_key_ff;
               rsp_in.expired_argument = pend_arg_ff;
               rsp_in.last             = 1'b0;
            end
            tbl_ctl.we = !remove && !stall;
         end
         S_FINISH: begin
            unit_op = UOP_ADD;
            unit_a  = now_ff;
            unit_b  = {1'b0, delay_ff};
            if ((cmd_ff != CMD_TICK) || pend_valid_ff) begin
               stall    = !out_free;
               load_rsp = out_free;
            end
            unique case (cmd_ff)
               CMD_SCHEDULE: begin
                  if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                     rsp_in.status = STAT_FULL;
                  end else begin
                     rsp_in.status = STAT_OK;
                     tbl_ctl.we    = out_free;
                  end
                  tbl_ctl.waddr = count_ff[IDX_W-1:0];
                  tbl_ctl.wdata = '{key: key_ff, argument: arg_ff, deadline: unit_res};
               end
               CMD_CANCEL: begin
                  rsp_in.status = found_ff ? STAT_OK : STAT_NOT_FOUND;
               end
               default: begin
                  rsp_in.kind             = KIND_EXPIRED;
                  rsp_in.status           = STAT_OK;
                  rsp_in.expired_key      = pend_key_ff;
                  rsp_in.expired_argument = pend_arg_ff;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         wr_ff         <= '0;
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         now_ff        <= '0;
         cmd_ff        <= CMD_SCHEDULE;
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cmd_ff        <= req_cmd;
                  idx_ff        <= '0;
                  wr_ff         <= '0;
                  found_ff      <= 1'b0;
                  pend_valid_ff <= 1'b0;
                  if (req_cmd == CMD_TICK) begin
                     now_ff <= unit_res;
                  end
               end
            end
            S_EVAL: begin
               if (!stall) begin
                  idx_ff <= idx_ff + CNT_W'(1);
                  if (!remove) begin
                     wr_ff <= wr_ff + CNT_W'(1);
                  end else if (cmd_ff == CMD_TICK) begin
                     pend_valid_ff <= 1'b1;
                  end else begin
                     found_ff <= 1'b1;
                  end
               end
            end
            S_FINISH: begin
               if (!stall) begin
                  pend_valid_ff <= 1'b0;
                  if (cmd_ff == CMD_SCHEDULE) begin
                     if (count_ff != CNT_W'(TABLE_DEPTH)) begin
                        count_ff <= count_ff + CNT_W'(1);
                     end
                  end else begin
                     count_ff <= wr_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff   <= req_data.callback_key;
         arg_ff   <= req_data.argument;
         delay_ff <= req_data.delay_ticks;
      end
      if ((state_ff == S_EVAL) && remove && !stall && (cmd_ff == CMD_TICK)) begin
         pend_key_ff <= rd_entry.key;
         pend_arg_ff <= rd_entry.argument;
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_EVAL) |-> (wr_ff <= idx_ff && idx_ff < count_ff))
      else $error("compaction write overtook read");

   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_STATUS) |->
         (rsp_ff.last && rsp_ff.expired_key == 32'd0 && rsp_ff.expired_argument == 32'd0))
      else $error("malformed status transfer");

   a_pend_tick: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (cmd_ff == CMD_TICK && state_ff != S_IDLE))
      else $error("held expiry outside a tick");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> !$past(load_rsp))
      else $error("result register overwritten while stalled");

endmodule

/* rtl/dctt_table.sv */
// Entry storage: one write port, one registered read port.
module dctt_table
   import dctt_pkg::*;
(
   input  logic        clock,
   input  tbl_ctl_type ctl,
   output entry_type   rd_data
);

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      rd_data_ff <= mem[ctl.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/dctt_unit.sv */
// Shared 32-bit add/subtract unit: deadline sum, time step, key match, wrap-aware expiry.
module dctt_unit
   import dctt_pkg::*;
(
   input  unit_op_type op,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] res,
   output logic        hit
);

   logic        sub;
   logic [31:0] b_opnd;

   assign sub    = (op != UOP_ADD);
   assign b_opnd = sub ? ~b : b;
   assign res    = a + b_opnd + {31'd0, sub};

   always_comb begin
      unique case (op)
         UOP_EQ:   hit = (res == 32'd0);
         UOP_PAST: hit = (res != 32'd0) && !res[31];
         default:  hit = 1'b0;
      endcase
   end

endmodule

/* tb/tb_timer_table_pkg.sv */
// Scoreboard for the deferred call timer table: predicts results and checks them.
`timescale 1ns / 1ps
package tb_timer_table_pkg;
   import dctt_pkg::*;

   class timer_table_scoreboard;
      // predicted table contents, oldest entry in slot 0
      logic [31:0] slot_key [TABLE_DEPTH];
      logic [31:0] slot_arg [TABLE_DEPTH];
      logic [31:0] slot_deadline [TABLE_DEPTH];
      int          occupied;
      logic [31:0] tick_count;

      rsp_type     due_results[$];

      int errors;
      int commands;
      int checked;
      int expired_seen;
      int full_seen;
      int miss_seen;
      int widest_tick;

      function new();
         occupied     = 0;
         tick_count   = '0;
         errors       = 0;
         commands     = 0;
         checked      = 0;
         expired_seen = 0;
         full_seen    = 0;
         miss_seen    = 0;
         widest_tick  = 0;
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      function void push_status(status_type st);
         rsp_type s;
         s        = '0;
         s.kind   = KIND_STATUS;
         s.status = st;
         s.last   = 1'b1;
         due_results.push_back(s);
      endfunction

      // one accepted transfer on the request side
      function void note_command(req_type r);
         rsp_type     held;
         bit          have_held;
         int          kept;
         int          fired;
         int          hit;
         logic [31:0] gap;
         commands++;
         if (r.command == CMD_SCHEDULE) begin
            if (occupied >= TABLE_DEPTH) begin
               push_status(STAT_FULL);
            end else begin
               slot_key[occupied]      = r.callback_key;
               slot_arg[occupied]      = r.argument;
               slot_deadline[occupied] = tick_count + {1'b0, r.delay_ticks};
               occupied++;
               push_status(STAT_OK);
            end
         end else if (r.command == CMD_CANCEL) begin
            hit = -1;
            for (int i = 0; i < occupied; i++) begin
               if (hit < 0 && slot_key[i] == r.callback_key) hit = i;
            end
            if (hit < 0) begin
               push_status(STAT_NOT_FOUND);
            end else begin
               for (int j = hit; j + 1 < occupied; j++) begin
                  slot_key[j]      = slot_key[j + 1];
                  slot_arg[j]      = slot_arg[j + 1];
                  slot_deadline[j] = slot_deadline[j + 1];
               end
               occupied--;
               push_status(STAT_OK);
            end
         end else if (r.command == CMD_TICK) begin
            tick_count = tick_count + 32'd1;
            kept       = 0;
            fired      = 0;
            have_held  = 0;
            held       = '0;
            for (int i = 0; i < occupied; i++) begin
               gap = tick_count - slot_deadline[i];
               // strictly past: difference nonzero and positive as signed
               if (gap != 32'd0 && !gap[31]) begin
                  if (have_held) due_results.push_back(held);
                  held                  = '0;
                  held.kind             = KIND_EXPIRED;
                  held.status           = STAT_OK;
                  held.expired_key      = slot_key[i];
                  held.expired_argument = slot_arg[i];
                  have_held             = 1;
                  fired++;
               end else begin
                  slot_key[kept]      = slot_key[i];
                  slot_arg[kept]      = slot_arg[i];
                  slot_deadline[kept] = slot_deadline[i];
                  kept++;
               end
            end
            occupied = kept;
            if (have_held) begin
               held.last = 1'b1;
               due_results.push_back(held);
            end
            if (fired > widest_tick) widest_tick = fired;
         end
      endfunction

      function void report_field(string name, logic [31:0] want, logic [31:0] got);
         errors++;
         if (errors <= 40)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      endfunction

      // one accepted transfer on the result side
      function void check_result(rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            errors++;
            if (errors <= 40)
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
            return;
         end
         want = due_results.pop_front();
         checked++;
         if (want.kind == KIND_EXPIRED) expired_seen++;
         if (want.status == STAT_FULL) full_seen++;
         if (want.status == STAT_NOT_FOUND) miss_seen++;
         if (got.kind !== want.kind)
            report_field("kind", want.kind, got.kind);
         if (got.status !== want.status)
            report_field("status", want.status, got.status);
         if (got.expired_key !== want.expired_key)
            report_field("expired_key", want.expired_key, got.expired_key);
         if (got.expired_argument !== want.expired_argument)
            report_field("expired_argument", want.expired_argument, got.expired_argument);
         if (got.last !== want.last)
            report_field("last", want.last, got.last);
      endfunction
   endclass

endpackage

/* tb/tb_top.sv */
// Top of the deferred call timer table testbench: clock, reset, stimulus and checks.
`timescale 1ns / 1ps
module tb_top;
   import dctt_pkg::*;
   import tb_timer_table_pkg::*;

   localparam int ITEM_TARGET  = 430;
   localparam int HOLD_AFTER   = 150;     // items sent before the long receiver hold-off
   localparam int LONG_HOLD    = 400;     // cycles of rsp_ready low, req_ready drops meanwhile
   localparam int DRAIN_CYCLES = 40;      // wait after the last due result is checked
   localparam int CYCLE_LIMIT  = 400_000;

   // receiver stall patterns
   typedef enum int {
      READY_ALWAYS,
      READY_HALF,
      READY_QUARTER,
      READY_MOSTLY
   } stall_mode_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   timer_table_scoreboard sb = new();

   int          burst_left;
   int          sent;
   int          cycle_count;
   bit          hold_request;
   bit          hold_done;
   logic [31:0] key_pool [8];

   deferred_call_timer_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Both sides sampled at the rising edge, before the block's own updates land.
   // A request and an older result in the same edge can be taken in either order.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_command(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
   end

   function automatic req_type mk(cmd_type cmd, logic [31:0] key, logic [31:0] arg,
                                  logic [30:0] delay);
      req_type r;
      r.command      = cmd;
      r.callback_key = key;
      r.argument     = arg;
      r.delay_ticks  = delay;
      return r;
   endfunction

   // Mostly small delays so entries expire within a few ticks; pooled keys so
   // cancels hit and duplicates exercise oldest-match removal. Long delays only
   // go with pooled keys, so a cancel can still clear them out of the table.
   function automatic req_type random_command();
      req_type     r;
      int          pick;
      int          dsel;
      r.command      = CMD_TICK;
      r.callback_key = $urandom();
      r.argument     = $urandom();
      r.delay_ticks  = 31'($urandom());
      pick           = $urandom_range(0, 99);
      if (pick < 40) begin
         r.command = CMD_SCHEDULE;
         if ($urandom_range(0, 3) == 0) begin
            r.delay_ticks = 31'($urandom_range(0, 12));
         end else begin
            r.callback_key = key_pool[$urandom_range(0, 7)];
            dsel           = $urandom_range(0, 9);
            if (dsel < 8)
               r.delay_ticks = 31'($urandom_range(0, 12));
            else if (dsel == 9)
               r.delay_ticks = 31'h7FFF_FFFF - 31'($urandom_range(0, 15));
         end
      end else if (pick < 60) begin
         r.command = CMD_CANCEL;
         if ($urandom_range(0, 6) != 0) r.callback_key = key_pool[$urandom_range(0, 7)];
      end else if (pick >= 95) begin
         r.command = CMD_RSVD;
      end
      return r;
   endfunction

   // Sender: bursts of random length, random gaps between them, and now and
   // then a long burst with no gaps at all. Valid stays up across back-to-back
   // items; only one nonblocking write to req_valid per edge.
   task automatic offer(input req_type r);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   // Receiver: stall pattern changes after each span of random length; once, after the
   // stimulus asks for it, a long hold-off so results back up and req_ready drops.
   initial begin
      stall_mode_type mode;
      int             span;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            hold_done = 1;
            repeat (LONG_HOLD) begin
               @(posedge clock);
               rsp_ready <= 1'b0;
            end
         end
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(10, 80);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               READY_ALWAYS:  rsp_ready <= 1'b1;
               READY_HALF:    rsp_ready <= 1'($urandom_range(0, 1));
               READY_QUARTER: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:       rsp_ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // Watchdog: cycle counter, generous limit.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout, %0d results still due", $time, sb.pending());
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      req_type     r;
      int          k;
      int          d;
      logic [31:0] dup_key;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_ready    = 1'b0;
      burst_left   = 0;
      sent         = 0;
      hold_request = 0;
      hold_done    = 0;
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      dup_key     = 32'h0000_00A5;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // tick on an empty table gives nothing; code three is dropped
      offer(mk(CMD_TICK, 32'h0, 32'h0, 31'h0));
      offer(mk(CMD_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
      // cancel on an empty table: not found
      offer(mk(CMD_CANCEL, 32'h0, 32'h0, 31'h0));
      // all-ones entry with the longest delay, then fill with delay zero
      offer(mk(CMD_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
      offer(mk(CMD_SCHEDULE, 32'h0, 32'h0, 31'h0));
      offer(mk(CMD_SCHEDULE, dup_key, 32'h1, 31'h0));
      offer(mk(CMD_SCHEDULE, dup_key, 32'h2, 31'h0));
      for (int i = 0; i < 12; i++)
         offer(mk(CMD_SCHEDULE, 32'd100 + i, $urandom(), 31'h0));
      // sixteen held: next schedule answers full
      offer(mk(CMD_SCHEDULE, 32'h1234_5678, 32'h8765_4321, 31'h0));
      // cancel the head entry, then the older of two duplicates
      offer(mk(CMD_CANCEL, 32'hFFFF_FFFF, 32'h0, 31'h0));
      offer(mk(CMD_CANCEL, dup_key, 32'h0, 31'h0));
      offer(mk(CMD_SCHEDULE, 32'h5555_5555, 32'hAAAA_AAAA, 31'h0));
      offer(mk(CMD_SCHEDULE, 32'hAAAA_AAAA, 32'h5555_5555, 31'h0));
      // all sixteen deadlines are behind now after one tick: widest burst
      offer(mk(CMD_TICK, $urandom(), $urandom(), 31'($urandom())));
      offer(mk(CMD_CANCEL, dup_key, 32'h0, 31'h0));
      sent = 25;

      // --- random part ---
      while (sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) begin
            // clump: several entries sharing a deadline, then enough ticks to
            // expire them together
            k = $urandom_range(2, 10);
            d = $urandom_range(0, 3);
            repeat (k) begin
               offer(mk(CMD_SCHEDULE, key_pool[$urandom_range(0, 7)], $urandom(),
                        31'(d)));
               sent++;
            end
            repeat (d + 2) begin
               offer(mk(CMD_TICK, $urandom(), $urandom(), 31'($urandom())));
               sent++;
            end
         end else begin
            r = random_command();
            offer(r);
            if (r.command != CMD_RSVD) sent++;
         end
         if (sent >= HOLD_AFTER) hold_request = 1;
      end
      req_valid <= 1'b0;

      // one edge so the last accepted command is in the scoreboard
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d commands, %0d results checked: %0d expired entries, %0d full,",
               sb.commands, sb.checked, sb.expired_seen, sb.full_seen);
      $display("%0d not found; widest tick gave %0d entries; %0d cycles",
               sb.miss_seen, sb.widest_tick, cycle_count);
      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
